>>> hw/rtl/kmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmq_pkg
// Shared types and constants for the key matrix event queue: sequencer
// states, action codes, register indexes, field widths and the event entry.
// ----------------------------------------------------------------------------
package kmq_pkg;

    localparam int MATRIX_ROWS_DEF = 15;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ROW_W    = 8;
    localparam int KEY_W    = 7;
    localparam int LEVEL_W  = 4;
    localparam int COUNT_W  = 16;
    localparam int CFG_W    = 8;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    localparam int MOD_ROW       = 14;
    localparam int MOD_SHIFT_BIT = 0;
    localparam int MOD_CTRL_BIT  = 1;

    localparam logic [CFG_W-1:0] DELAY_RST  = 8'd12;
    localparam logic [CFG_W-1:0] PERIOD_RST = 8'd1;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_COMMIT = 2'd1;
    localparam logic [1:0] ACT_POP    = 2'd2;

    localparam logic REG_DELAY  = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_SCAN,
        ST_HOLD,
        ST_REP,
        ST_DONE
    } kmq_state_t;

    typedef struct packed {
        logic             rep;
        logic             ctrl;
        logic             shift;
        logic [KEY_W-1:0] code;
    } kmq_event_t;

endpackage : kmq_pkg
`default_nettype wire

>>> hw/rtl/key_matrix_event_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_matrix_event_queue_unit
// Key matrix scanner with typematic repeat and an event FIFO. Row samples
// fill a pending matrix, a commit shifts it in and scans for new presses one
// key per cycle, and pops drain one event each.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | sink      | in_valid / in_stall | action, row_index, row_bits
//  out     | source    | out_valid/out_stall | event_valid, key_code,
//          |           |                     | shift_held, ctrl_held,
//          |           |                     | is_repeat, queue_level
//  cfg     | APB slave | psel/penable/pready | typematic delay, typematic rate
//
//  A row sample, pop or unused action goes straight to the done state.
//  A commit copies, scans and checks the hold, then takes a repeat step when the
//  repeat key is still held: the key scan tests one matrix position per cycle.
//  Reset clears the three matrices, pointers and repeat state, and loads the
//  register defaults.
//  The next item is taken while a result still waits on a stalled out beat.
// ----------------------------------------------------------------------------
module key_matrix_event_queue_unit #(
    parameter int MATRIX_ROWS = kmq_pkg::MATRIX_ROWS_DEF,
    parameter int QUEUE_DEPTH = kmq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   action,
    input  wire logic [3:0]                   row_index,
    input  wire logic [kmq_pkg::ROW_W-1:0]    row_bits,

    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              event_valid,
    output logic [kmq_pkg::KEY_W-1:0]         key_code,
    output logic                              shift_held,
    output logic                              ctrl_held,
    output logic                              is_repeat,
    output logic [kmq_pkg::LEVEL_W-1:0]       queue_level,

    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [kmq_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [kmq_pkg::DATA_W-1:0]   pwdata,
    output logic [kmq_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    localparam int RIW = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam logic [kmq_pkg::KEY_W-1:0] LAST_KEY =
        kmq_pkg::KEY_W'(8 * MATRIX_ROWS - 1);
    localparam logic [4:0] ROWS_LIM = 5'(MATRIX_ROWS);

    kmq_pkg::kmq_state_t state_reg, state_next;

    logic [kmq_pkg::ROW_W-1:0]   pend_rows_reg [MATRIX_ROWS];
    logic [kmq_pkg::ROW_W-1:0]   cur_rows_reg  [MATRIX_ROWS];
    logic [kmq_pkg::ROW_W-1:0]   prev_rows_reg [MATRIX_ROWS];
    kmq_pkg::kmq_event_t         event_mem     [QUEUE_DEPTH];

    logic [PW-1:0]               wp_reg, rp_reg;
    logic [PW-1:0]               wp_inc, rp_inc;
    logic [kmq_pkg::KEY_W-1:0]   key_cnt_reg;
    logic [kmq_pkg::KEY_W-1:0]   rkey_reg;
    logic                        ract_reg;
    logic [kmq_pkg::COUNT_W-1:0] rcount_reg;
    logic [kmq_pkg::CFG_W-1:0]   delay_reg, period_reg;

    kmq_pkg::kmq_event_t         rd_data_reg;
    logic                        ev_valid_reg;

    logic                        out_valid_reg;
    logic                        out_ev_valid_reg;
    kmq_pkg::kmq_event_t         out_ev_reg;
    logic [kmq_pkg::LEVEL_W-1:0] out_level_reg;

    logic                        accept;
    logic                        out_free;
    logic                        load_out;
    logic                        copy_en;
    logic                        scan_en;
    logic                        hold_en;
    logic                        rep_en;
    logic                        push_req;
    logic                        queue_full;
    kmq_pkg::kmq_event_t         push_ev;
    logic [kmq_pkg::ROW_W-1:0]   mod_row;

    logic [RIW-1:0]              rd_row;
    logic [2:0]                  rd_bit;
    logic [kmq_pkg::ROW_W-1:0]   rd_cur, rd_prev;
    logic                        fresh_bit;
    logic                        held_bit;
    logic                        count_ge;
    logic [PW:0]                 level;
    logic                        cfg_wr;

    assign in_stall = (state_reg != kmq_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kmq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == kmq_pkg::ACT_COMMIT)
                        state_next = kmq_pkg::ST_COPY;
                    else
                        state_next = kmq_pkg::ST_DONE;
                end
            end
            kmq_pkg::ST_COPY: state_next = kmq_pkg::ST_SCAN;
            kmq_pkg::ST_SCAN:
            begin
                if (key_cnt_reg == LAST_KEY)
                    state_next = kmq_pkg::ST_HOLD;
            end
            kmq_pkg::ST_HOLD:
            begin
                if (ract_reg && held_bit)
                    state_next = kmq_pkg::ST_REP;
                else
                    state_next = kmq_pkg::ST_DONE;
            end
            kmq_pkg::ST_REP:  state_next = kmq_pkg::ST_DONE;
            kmq_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = kmq_pkg::ST_IDLE;
            end
            default: state_next = kmq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        copy_en  = 1'b0;
        scan_en  = 1'b0;
        hold_en  = 1'b0;
        rep_en   = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            kmq_pkg::ST_IDLE: ;
            kmq_pkg::ST_COPY: copy_en  = 1'b1;
            kmq_pkg::ST_SCAN: scan_en  = 1'b1;
            kmq_pkg::ST_HOLD: hold_en  = 1'b1;
            kmq_pkg::ST_REP:  rep_en   = 1'b1;
            kmq_pkg::ST_DONE: load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= kmq_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // single matrix read port: scan position, or the repeat key when checking hold
    assign rd_row  = hold_en ? rkey_reg[3 +: RIW] : key_cnt_reg[3 +: RIW];
    assign rd_bit  = hold_en ? rkey_reg[2:0] : key_cnt_reg[2:0];
    assign rd_cur  = cur_rows_reg[rd_row];
    assign rd_prev = prev_rows_reg[rd_row];

    assign fresh_bit = rd_cur[rd_bit] && !rd_prev[rd_bit];
    assign held_bit  = rd_cur[rd_bit] && ({1'b0, rkey_reg[6:3]} < ROWS_LIM);
    assign count_ge  = $signed(rcount_reg) >= $signed({8'b0, delay_reg});

    generate
        if (MATRIX_ROWS > kmq_pkg::MOD_ROW)
        begin : g_mod
            assign mod_row = cur_rows_reg[kmq_pkg::MOD_ROW];
        end
        else
        begin : g_no_mod
            assign mod_row = '0;
        end
    endgenerate

    assign wp_inc = (wp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign queue_full = (wp_inc == rp_reg);

    assign push_req      = (scan_en && fresh_bit) || (rep_en && count_ge);
    assign push_ev.rep   = rep_en;
    assign push_ev.ctrl  = mod_row[kmq_pkg::MOD_CTRL_BIT];
    assign push_ev.shift = mod_row[kmq_pkg::MOD_SHIFT_BIT];
    assign push_ev.code  = rep_en ? rkey_reg : key_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push_req && !queue_full)
            event_mem[wp_reg] <= push_ev;
        if (accept && (action == kmq_pkg::ACT_POP))
            rd_data_reg <= event_mem[rp_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MATRIX_ROWS; r++)
            begin
                pend_rows_reg[r] <= '0;
                cur_rows_reg[r]  <= '0;
                prev_rows_reg[r] <= '0;
            end
        end
        else
        begin
            if (accept && (action == kmq_pkg::ACT_SAMPLE)
                && ({1'b0, row_index} < ROWS_LIM))
                pend_rows_reg[row_index[RIW-1:0]] <= row_bits;
            if (copy_en)
            begin
                for (int r = 0; r < MATRIX_ROWS; r++)
                begin
                    prev_rows_reg[r] <= cur_rows_reg[r];
                    cur_rows_reg[r]  <= pend_rows_reg[r];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            key_cnt_reg  <= '0;
            rkey_reg     <= '0;
            ract_reg     <= 1'b0;
            rcount_reg   <= '0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            if (push_req && !queue_full)
                wp_reg <= wp_inc;

            if (accept)
                ev_valid_reg <= (action == kmq_pkg::ACT_POP) && (rp_reg != wp_reg);

            if (accept && (action == kmq_pkg::ACT_POP) && (rp_reg != wp_reg))
                rp_reg <= rp_inc;

            if (copy_en)
                key_cnt_reg <= '0;
            else if (scan_en)
                key_cnt_reg <= key_cnt_reg + 1'b1;

            if (scan_en && fresh_bit && (!ract_reg || (rkey_reg != key_cnt_reg)))
            begin
                rkey_reg   <= key_cnt_reg;
                ract_reg   <= 1'b1;
                rcount_reg <= '0;
            end

            if (hold_en && ract_reg)
            begin
                if (held_bit)
                    rcount_reg <= rcount_reg + 1'b1;
                else
                    ract_reg <= 1'b0;
            end

            if (rep_en && count_ge)
                rcount_reg <= rcount_reg - {8'b0, period_reg};
        end
    end

    always_comb
    begin
        if (wp_reg >= rp_reg)
            level = {1'b0, wp_reg} - {1'b0, rp_reg};
        else
            level = {1'b0, wp_reg} + (PW+1)'(QUEUE_DEPTH) - {1'b0, rp_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_ev_valid_reg <= ev_valid_reg;
            out_ev_reg       <= ev_valid_reg ? rd_data_reg : '0;
            out_level_reg    <= kmq_pkg::LEVEL_W'(level);
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_valid = out_ev_valid_reg;
    assign key_code    = out_ev_reg.code;
    assign shift_held  = out_ev_reg.shift;
    assign ctrl_held   = out_ev_reg.ctrl;
    assign is_repeat   = out_ev_reg.rep;
    assign queue_level = out_level_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= kmq_pkg::DELAY_RST;
            period_reg <= kmq_pkg::PERIOD_RST;
        end
        else if (cfg_wr && (paddr[1:0] == 2'b00))
        begin
            unique case (paddr[2])
                kmq_pkg::REG_DELAY:  delay_reg  <= pwdata[kmq_pkg::CFG_W-1:0];
                kmq_pkg::REG_PERIOD: period_reg <= pwdata[kmq_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            kmq_pkg::REG_DELAY:  prdata = {24'b0, delay_reg};
            kmq_pkg::REG_PERIOD: prdata = {24'b0, period_reg};
            default:             prdata = '0;
        endcase
    end

endmodule : key_matrix_event_queue_unit
`default_nettype wire

>>> hw/rtl/kmq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmq_checker
// Port-level checks for the key matrix event queue, bound to the top level.
// ----------------------------------------------------------------------------
module kmq_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_stall,
    input wire logic [1:0]                   action,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic                         event_valid,
    input wire logic [kmq_pkg::KEY_W-1:0]    key_code,
    input wire logic                         shift_held,
    input wire logic                         ctrl_held,
    input wire logic                         is_repeat,
    input wire logic [kmq_pkg::LEVEL_W-1:0]  queue_level
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({event_valid, key_code, shift_held, ctrl_held,
                        is_repeat, queue_level}))
        else $error("out beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on back-to-back cycles");

    a_commit_scans: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == kmq_pkg::ACT_COMMIT) |=> ##1 in_stall)
        else $error("commit finished without a scan");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !event_valid |-> (key_code == '0) && !shift_held
            && !ctrl_held && !is_repeat)
        else $error("event fields set on a beat without an event");

endmodule : kmq_checker

bind key_matrix_event_queue_unit kmq_checker u_kmq_checker (.*);
`default_nettype wire
